### hw/rtl/dfa_string_matcher_defines.svh
`ifndef DFA_STRING_MATCHER_DEFINES_SVH
`define DFA_STRING_MATCHER_DEFINES_SVH

// checks that are off while reset is low
`define DSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checks that also look at reset itself
`define DSM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/dsm_pkg.sv
package dsm_pkg;

  localparam int DSM_MAX_STATES  = 64;
  localparam int DSM_MAX_SYMBOLS = 16;

  localparam int DSM_OP_W     = 3;
  localparam int DSM_STATE_W  = 6;
  localparam int DSM_SYM_W    = 4;
  localparam int DSM_CHAR_W   = 8;
  localparam int DSM_ASIZE_W  = 5;
  localparam int DSM_ALPHA_DEPTH = 2 ** DSM_SYM_W;
  localparam int DSM_Q_DEPTH  = 2;

  typedef enum logic [DSM_OP_W-1:0] {
    OP_LOAD_SYM   = 3'd0,
    OP_LOAD_TRANS = 3'd1,
    OP_LOAD_ACC   = 3'd2,
    OP_CHAR       = 3'd3,
    OP_EOS        = 3'd4
  } dsm_op_t;

  typedef enum logic [1:0] {
    CMD_TRANS = 2'd0,
    CMD_ACC   = 2'd1,
    CMD_CHAR  = 2'd2,
    CMD_EOS   = 2'd3
  } dsm_cmd_kind_t;

  typedef struct packed {
    logic [DSM_OP_W-1:0]    operation;
    logic [DSM_STATE_W-1:0] state_index;
    logic [DSM_SYM_W-1:0]   symbol_index;
    logic [DSM_STATE_W-1:0] next_state;
    logic                   transition_valid;
    logic [DSM_CHAR_W-1:0]  char_value;
    logic                   accept_flag;
  } dsm_in_t;

  typedef struct packed {
    logic                   accepted;
    logic                   hit_dead;
    logic [DSM_STATE_W-1:0] end_state;
  } dsm_out_t;

  // classified request handed from front to back
  typedef struct packed {
    dsm_cmd_kind_t          kind;
    logic [DSM_STATE_W-1:0] st;
    logic [DSM_SYM_W-1:0]   col;
    logic [DSM_STATE_W-1:0] nxt;
    logic                   ok;
    logic                   flag;
  } dsm_cmd_t;

endpackage

### hw/rtl/dfa_string_matcher.sv
// one request per cycle each way while nothing stalls, characters and end-of-string back to back
// verdict path after an end-of-string request is taken: queue, accept read, output register
// character rate is set by the transition memory read feeding the next read address
// reset (synchronous, rst_n low) clears state, dead flag, alphabet size, accept marks, queue
// alphabet and transition memories are not cleared and read undefined until loaded
module dfa_string_matcher import dsm_pkg::*; #(
  parameter int MAX_STATES  = DSM_MAX_STATES,
  parameter int MAX_SYMBOLS = DSM_MAX_SYMBOLS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dsm_in_t                in_req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dsm_out_t               out_req,
  input  logic                   cfg_we,
  input  logic [DSM_ASIZE_W-1:0] cfg_wdata
);

  logic     f_valid;
  logic     f_ready;
  dsm_cmd_t f_cmd;
  logic     b_valid;
  logic     b_ready;
  dsm_cmd_t b_cmd;

  dsm_front #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  dsm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_cmd)
  );

  dsm_back #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req)
  );

endmodule

### hw/rtl/dsm_ram.sv
module dsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/dsm_front.sv
module dsm_front import dsm_pkg::*; #(
  parameter int MAX_STATES  = DSM_MAX_STATES,
  parameter int MAX_SYMBOLS = DSM_MAX_SYMBOLS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dsm_in_t                in_req,
  input  logic                   cfg_we,
  input  logic [DSM_ASIZE_W-1:0] cfg_wdata,
  output logic                   cmd_valid,
  input  logic                   cmd_ready,
  output dsm_cmd_t               cmd
);

  localparam int NA = (MAX_SYMBOLS < DSM_ALPHA_DEPTH) ? MAX_SYMBOLS : DSM_ALPHA_DEPTH;
  localparam int KW = (NA > 1) ? $clog2(NA) : 1;

  logic [DSM_CHAR_W-1:0]  alpha_r [NA];
  logic [DSM_ASIZE_W-1:0] asize_r;
  logic [NA-1:0]          hit;
  logic [KW-1:0]          hit_idx;
  logic                   found;
  logic                   fwd;
  logic                   alpha_we;
  logic                   st_ok;
  logic                   sym_ok;
  logic                   nxt_ok;

  assign st_ok  = int'(in_req.state_index) < MAX_STATES;
  assign sym_ok = int'(in_req.symbol_index) < MAX_SYMBOLS;
  assign nxt_ok = int'(in_req.next_state) < MAX_STATES;

  // first alphabet entry below the configured size that matches
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      hit[i] = (asize_r > DSM_ASIZE_W'(i)) && (alpha_r[i] == in_req.char_value);
    end
    hit_idx = '0;
    for (int i = NA - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = KW'(i);
      end
    end
  end

  assign found = |hit;

  always_comb begin
    fwd      = 1'b0;
    alpha_we = 1'b0;
    cmd.kind = CMD_CHAR;
    cmd.st   = in_req.state_index;
    cmd.col  = in_req.symbol_index;
    cmd.nxt  = in_req.next_state;
    cmd.ok   = 1'b0;
    cmd.flag = in_req.accept_flag;
    unique case (in_req.operation)
      OP_LOAD_SYM: begin
        alpha_we = sym_ok;
      end
      OP_LOAD_TRANS: begin
        cmd.kind = CMD_TRANS;
        fwd      = st_ok && sym_ok;
        cmd.ok   = in_req.transition_valid && nxt_ok;
      end
      OP_LOAD_ACC: begin
        cmd.kind = CMD_ACC;
        fwd      = st_ok;
      end
      OP_CHAR: begin
        cmd.kind = CMD_CHAR;
        fwd      = 1'b1;
        cmd.ok   = found;
        cmd.col  = DSM_SYM_W'(hit_idx);
      end
      OP_EOS: begin
        cmd.kind = CMD_EOS;
        fwd      = 1'b1;
      end
      default: begin
        fwd = 1'b0;
      end
    endcase
  end

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid && fwd;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && alpha_we) begin
      alpha_r[in_req.symbol_index[KW-1:0]] <= in_req.char_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asize_r <= '0;
    end else if (cfg_we) begin
      asize_r <= cfg_wdata;
    end
  end

endmodule

### hw/rtl/dsm_fifo.sv
module dsm_fifo import dsm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  dsm_cmd_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output dsm_cmd_t pop_data
);

  localparam int PW = $clog2(DSM_Q_DEPTH);

  dsm_cmd_t      buf_r [DSM_Q_DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [PW:0]   cnt_r;
  logic          push;
  logic          pop;

  assign push_ready = cnt_r != (PW + 1)'(DSM_Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = buf_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/dsm_back.sv
module dsm_back import dsm_pkg::*; #(
  parameter int MAX_STATES  = DSM_MAX_STATES,
  parameter int MAX_SYMBOLS = DSM_MAX_SYMBOLS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  dsm_cmd_t cmd,
  output logic     out_valid,
  input  logic     out_ready,
  output dsm_out_t out_req
);

  localparam int SW    = $clog2(MAX_STATES);
  localparam int CW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int DEPTH = MAX_STATES * MAX_SYMBOLS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] NSYM = AW'(MAX_SYMBOLS);

  logic [SW-1:0]   state_r;
  logic [SW-1:0]   state_nxt;
  logic            dead_r;
  logic            dead_nxt;
  logic            pend_r;
  logic            pend_nxt;
  logic [SW:0]     trans_rdata;
  logic [SW:0]     trans_wdata;
  logic            trans_we;
  logic            trans_re;
  logic [AW-1:0]   trans_waddr;
  logic [AW-1:0]   trans_raddr;
  logic [SW-1:0]   cur_state;
  logic            cur_dead;
  logic [SW-1:0]   cmd_st;
  logic [SW-1:0]   cmd_nxt;
  logic [CW-1:0]   cmd_col;
  logic            acc_we;
  logic            acc_re;
  logic            acc_rdata;
  logic [MAX_STATES-1:0] acc_vld_r;
  logic            pop;
  logic            s1_v_r;
  logic            s1_dead_r;
  logic [SW-1:0]   s1_state_r;
  logic            s1_avld_r;
  logic            s1_move;
  logic            s1_free;
  logic            out_v_r;
  dsm_out_t        out_r;

  assign cmd_st  = SW'(cmd.st);
  assign cmd_nxt = SW'(cmd.nxt);
  assign cmd_col = CW'(cmd.col);

  // live state folds in the transition read issued last cycle
  assign cur_state = (pend_r && trans_rdata[SW]) ? trans_rdata[SW-1:0] : state_r;
  assign cur_dead  = dead_r || (pend_r && !trans_rdata[SW]);

  assign s1_move   = s1_v_r && (!out_v_r || out_ready);
  assign s1_free   = !s1_v_r || s1_move;
  assign cmd_ready = (cmd.kind != CMD_EOS) || s1_free;
  assign pop       = cmd_valid && cmd_ready;

  assign trans_we    = pop && (cmd.kind == CMD_TRANS);
  assign trans_waddr = AW'(cmd_st) * NSYM + AW'(cmd_col);
  assign trans_wdata = {cmd.ok, cmd.ok ? cmd_nxt : {SW{1'b0}}};
  assign trans_re    = pop && (cmd.kind == CMD_CHAR) && cmd.ok && !cur_dead;
  assign trans_raddr = AW'(cur_state) * NSYM + AW'(cmd_col);

  assign acc_we = pop && (cmd.kind == CMD_ACC);
  assign acc_re = pop && (cmd.kind == CMD_EOS);

  dsm_ram #(
    .WIDTH (SW + 1),
    .DEPTH (DEPTH)
  ) u_trans_ram (
    .clk   (clk),
    .we    (trans_we),
    .waddr (trans_waddr),
    .wdata (trans_wdata),
    .re    (trans_re),
    .raddr (trans_raddr),
    .rdata (trans_rdata)
  );

  dsm_ram #(
    .WIDTH (1),
    .DEPTH (MAX_STATES)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (cmd_st),
    .wdata (cmd.flag),
    .re    (acc_re),
    .raddr (cur_state),
    .rdata (acc_rdata)
  );

  always_comb begin
    state_nxt = cur_state;
    dead_nxt  = cur_dead;
    pend_nxt  = 1'b0;
    if (pop) begin
      case (cmd.kind)
        CMD_CHAR: begin
          if (!cur_dead) begin
            pend_nxt = cmd.ok;
            dead_nxt = !cmd.ok;
          end
        end
        CMD_EOS: begin
          state_nxt = '0;
          dead_nxt  = 1'b0;
        end
        default: begin
          pend_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= '0;
      dead_r    <= 1'b0;
      pend_r    <= 1'b0;
      acc_vld_r <= '0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dead_r  <= dead_nxt;
      pend_r  <= pend_nxt;
      if (acc_we) begin
        acc_vld_r[cmd_st] <= 1'b1;
      end
      if (acc_re) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_re) begin
      s1_dead_r  <= cur_dead;
      s1_state_r <= cur_state;
      s1_avld_r  <= acc_vld_r[cur_state];
    end
    if (s1_move) begin
      out_r.accepted  <= !s1_dead_r && s1_avld_r && acc_rdata;
      out_r.hit_dead  <= s1_dead_r;
      out_r.end_state <= DSM_STATE_W'(s1_state_r);
    end
  end

  assign out_valid = out_v_r;
  assign out_req   = out_r;

endmodule

### hw/rtl/dsm_checker.sv
`include "dfa_string_matcher_defines.svh"

module dsm_checker import dsm_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input dsm_out_t out_req
);

  `DSM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `DSM_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_req), "result changed while stalled")
  `DSM_ASSERT(a_dead_reject, out_valid && out_req.hit_dead |-> !out_req.accepted, "dead string accepted")
  `DSM_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind dfa_string_matcher dsm_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_req   (out_req)
);

### bench/dfa_string_matcher_tb.sv
module dfa_string_matcher_tb;
  import dsm_pkg::*;

  localparam int LIMIT = 200000;
  localparam int LAST_OP_CODE = (1 << DSM_OP_W) - 1;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  dsm_in_t in_req;
  logic out_valid;
  logic out_ready = 1'b0;
  dsm_out_t out_req;
  logic cfg_we;
  logic [DSM_ASIZE_W-1:0] cfg_wdata;

  // automaton mirror
  bit [DSM_CHAR_W-1:0] alpha_tbl [DSM_MAX_SYMBOLS];
  bit alpha_loaded [DSM_MAX_SYMBOLS];
  bit [DSM_STATE_W-1:0] trans_target [DSM_MAX_STATES][DSM_MAX_SYMBOLS];
  bit trans_live [DSM_MAX_STATES][DSM_MAX_SYMBOLS];
  bit trans_loaded [DSM_MAX_STATES][DSM_MAX_SYMBOLS];
  bit accept_mark [DSM_MAX_STATES];
  bit [DSM_STATE_W-1:0] run_state;
  bit run_dead;
  bit [DSM_ASIZE_W-1:0] alpha_size;
  dsm_out_t verdict_q [$];

  int in_idle_pct = 34;
  int out_idle_pct = 83;
  int hold_cycles = 0;
  int errors = 0;
  int cycles = 0;
  int requests_sent = 0;
  int strings_sent = 0;
  int verdicts_checked = 0;
  int accepted_seen = 0;
  int dead_seen = 0;
  int size_settings = 0;

  dfa_string_matcher DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_req(out_req),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts pending", cycles, verdict_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int first_column(bit [DSM_CHAR_W-1:0] ch);
    int lim;
    lim = (alpha_size > DSM_MAX_SYMBOLS) ? DSM_MAX_SYMBOLS : alpha_size;
    for (int k = 0; k < lim; k++) begin
      if (alpha_tbl[k] == ch) return k;
    end
    return -1;
  endfunction

  function automatic void track_request(dsm_in_t r);
    int col;
    dsm_out_t v;
    case (r.operation)
      OP_LOAD_SYM: begin
        alpha_tbl[r.symbol_index] = r.char_value;
        alpha_loaded[r.symbol_index] = 1'b1;
      end
      OP_LOAD_TRANS: begin
        trans_live[r.state_index][r.symbol_index] = r.transition_valid;
        trans_target[r.state_index][r.symbol_index] = r.transition_valid ? r.next_state : '0;
        trans_loaded[r.state_index][r.symbol_index] = 1'b1;
      end
      OP_LOAD_ACC: accept_mark[r.state_index] = r.accept_flag;
      OP_CHAR: begin
        if (!run_dead) begin
          col = first_column(r.char_value);
          if (col >= 0 && trans_live[run_state][col]) run_state = trans_target[run_state][col];
          else run_dead = 1'b1;
        end
      end
      OP_EOS: begin
        v.accepted = !run_dead && accept_mark[run_state];
        v.hit_dead = run_dead;
        v.end_state = run_state;
        verdict_q.push_back(v);
        run_state = '0;
        run_dead = 1'b0;
        strings_sent++;
      end
      default: ;
    endcase
  endfunction

  function automatic dsm_in_t random_fields();
    dsm_in_t r;
    r.operation = DSM_OP_W'($urandom_range(LAST_OP_CODE));
    r.state_index = DSM_STATE_W'($urandom_range(DSM_MAX_STATES - 1));
    r.symbol_index = DSM_SYM_W'($urandom_range(DSM_MAX_SYMBOLS - 1));
    r.next_state = DSM_STATE_W'($urandom_range(DSM_MAX_STATES - 1));
    r.transition_valid = 1'($urandom_range(1));
    r.char_value = DSM_CHAR_W'($urandom_range(255));
    r.accept_flag = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic void check_verdict(dsm_out_t got);
    dsm_out_t want;
    if (verdict_q.size() == 0) begin
      errors++;
      $display("%0t: verdict with none pending, expected nothing got %p", $time, got);
      return;
    end
    want = verdict_q.pop_front();
    verdicts_checked++;
    if (got.accepted === 1'b1) accepted_seen++;
    if (got.hit_dead === 1'b1) dead_seen++;
    if (got.accepted !== want.accepted) begin
      errors++;
      $display("%0t: accepted expected %0b got %0b", $time, want.accepted, got.accepted);
    end
    if (got.hit_dead !== want.hit_dead) begin
      errors++;
      $display("%0t: hit_dead expected %0b got %0b", $time, want.hit_dead, got.hit_dead);
    end
    if (got.end_state !== want.end_state) begin
      errors++;
      $display("%0t: end_state expected %0d got %0d", $time, want.end_state, got.end_state);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_verdict(out_req);
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_request(dsm_in_t r);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    track_request(r);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_alphabet_size(bit [DSM_ASIZE_W-1:0] size);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    alpha_size = size;
    size_settings++;
  endtask

  task automatic load_symbol(bit [DSM_SYM_W-1:0] col, bit [DSM_CHAR_W-1:0] ch);
    dsm_in_t r;
    r = random_fields();
    r.operation = OP_LOAD_SYM;
    r.symbol_index = col;
    r.char_value = ch;
    send_request(r);
  endtask

  task automatic load_transition(bit [DSM_STATE_W-1:0] st, bit [DSM_SYM_W-1:0] col,
                                 bit [DSM_STATE_W-1:0] nxt, bit ok);
    dsm_in_t r;
    r = random_fields();
    r.operation = OP_LOAD_TRANS;
    r.state_index = st;
    r.symbol_index = col;
    r.next_state = nxt;
    r.transition_valid = ok;
    send_request(r);
  endtask

  task automatic load_accept(bit [DSM_STATE_W-1:0] st, bit flag);
    dsm_in_t r;
    r = random_fields();
    r.operation = OP_LOAD_ACC;
    r.state_index = st;
    r.accept_flag = flag;
    send_request(r);
  endtask

  // a live step never reads a transition entry that was never loaded
  task automatic send_char(bit [DSM_CHAR_W-1:0] ch);
    int col;
    dsm_in_t r;
    col = first_column(ch);
    if (!run_dead && col >= 0 && !trans_loaded[run_state][col]) begin
      load_transition(run_state, DSM_SYM_W'(col),
                      DSM_STATE_W'(($urandom_range(99) < 70) ? $urandom_range(7)
                                                              : $urandom_range(63)),
                      $urandom_range(99) < 85);
    end
    r = random_fields();
    r.operation = OP_CHAR;
    r.char_value = ch;
    send_request(r);
  endtask

  task automatic send_eos();
    dsm_in_t r;
    r = random_fields();
    r.operation = OP_EOS;
    send_request(r);
  endtask

  task automatic send_unknown_op();
    dsm_in_t r;
    r = random_fields();
    r.operation = DSM_OP_W'($urandom_range(int'(OP_EOS) + 1, LAST_OP_CODE));
    send_request(r);
  endtask

  task automatic test_reset_verdict();
    send_eos();
    send_unknown_op();
    send_eos();
  endtask

  task automatic test_empty_alphabet();
    send_char(8'h61);
    send_char(8'h00);
    send_eos();
  endtask

  task automatic test_directed_strings();
    set_alphabet_size(5'd3);
    load_symbol(4'd0, 8'h00);
    load_symbol(4'd1, 8'hFF);
    load_symbol(4'd2, 8'h00);
    load_symbol(4'd15, 8'h80);
    load_transition(6'd0, 4'd0, 6'd63, 1'b1);
    load_transition(6'd63, 4'd1, 6'd21, 1'b1);
    load_transition(6'd21, 4'd0, 6'd5, 1'b0);
    load_transition(6'd0, 4'd15, 6'd0, 1'b1);
    load_accept(6'd63, 1'b1);
    load_accept(6'd21, 1'b1);
    send_char(8'h00);
    send_eos();
    send_char(8'h00);
    send_char(8'hFF);
    send_eos();
    // missing transition
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h00);
    send_eos();
    // unknown character, then a character while dead
    send_char(8'h55);
    send_char(8'h00);
    send_eos();
    // load in the middle of a string
    send_char(8'h00);
    load_accept(6'd63, 1'b0);
    send_eos();
  endtask

  task automatic random_load();
    case ($urandom_range(2))
      0: load_symbol(DSM_SYM_W'($urandom_range(15)), DSM_CHAR_W'($urandom_range(255)));
      1: load_transition(DSM_STATE_W'($urandom_range(63)), DSM_SYM_W'($urandom_range(15)),
                         DSM_STATE_W'($urandom_range(63)), 1'($urandom_range(1)));
      default: load_accept(DSM_STATE_W'(($urandom_range(99) < 70) ? $urandom_range(7)
                                                                  : $urandom_range(63)),
                           1'($urandom_range(1)));
    endcase
  endtask

  task automatic test_random_traffic(int in_pct, int out_pct, int size, int n);
    int count;
    int pick;
    int len;
    int lim;
    set_alphabet_size(DSM_ASIZE_W'(size));
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    for (int k = 0; k < DSM_MAX_SYMBOLS; k++) begin
      if (!alpha_loaded[k]) load_symbol(DSM_SYM_W'(k), DSM_CHAR_W'($urandom_range(255)));
    end
    lim = (alpha_size > DSM_MAX_SYMBOLS) ? DSM_MAX_SYMBOLS : alpha_size;
    count = 0;
    while (count < n) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_unknown_op();
      end else if (pick < 12) begin
        random_load();
        count++;
      end else if (pick < 16) begin
        if ($urandom_range(1)) send_eos();
        else send_char(DSM_CHAR_W'($urandom_range(255)));
        count++;
      end else begin
        len = $urandom_range(6);
        for (int j = 0; j < len; j++) begin
          if (lim > 0 && $urandom_range(9) != 0) send_char(alpha_tbl[$urandom_range(lim - 1)]);
          else send_char(DSM_CHAR_W'($urandom_range(255)));
          count++;
        end
        send_eos();
        count++;
      end
    end
  endtask

  // receiver holds off while strings keep coming so the block fills up
  task automatic test_backpressure();
    wait_quiet();
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_cycles = 150;
    repeat (24) begin
      send_char(alpha_tbl[0]);
      send_eos();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_verdict();
    test_empty_alphabet();
    test_directed_strings();
    test_random_traffic(34, 83, 31, 100);
    test_random_traffic(83, 34, $urandom_range(1, 15), 100);
    test_random_traffic(0, 0, 16, 100);
    test_backpressure();
    wait_quiet();
    $display("sent %0d requests making %0d strings over %0d alphabet size settings",
             requests_sent, strings_sent, size_settings);
    $display("checked %0d verdicts: %0d accepted, %0d dead, %0d mismatches",
             verdicts_checked, accepted_seen, dead_seen, errors);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/dsm_pkg.sv
hw/rtl/dsm_ram.sv
hw/rtl/dsm_front.sv
hw/rtl/dsm_fifo.sv
hw/rtl/dsm_back.sv
hw/rtl/dfa_string_matcher.sv
hw/rtl/dsm_checker.sv
bench/dfa_string_matcher_tb.sv
